@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every rising edge outside reset.
`define PRQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence must hold in the cycle after the antecedent.
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/prq_pkg.sv @@
// ----------------------------------------------------------------------------
// prq_pkg
// Types, widths and register codes shared by the preflight readiness qualifier.
// ----------------------------------------------------------------------------
package prq_pkg;

  // Width of the tick arithmetic and of the saturating counters.
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 16;

  // Fixed field widths of the ports and registers.
  localparam int NOW_W       = 32;
  localparam int CFG_TIME_W  = 32;
  localparam int CFG_COUNT_W = 16;
  localparam int OUT_COUNT_W = 16;
  localparam int REQ_W       = 3;
  localparam int HEALTH_W    = 3;
  localparam int UNMET_W     = 7;
  localparam int FLAGS_W     = 5;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int INDEX_W     = 3;

  // Comparison widths wide enough for either operand.
  localparam int TIME_CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
  localparam int CNT_CMP_W  = (COUNT_BITS > CFG_COUNT_W) ? COUNT_BITS : CFG_COUNT_W;

  // Item kinds.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_POLL   = 1'b1;

  // Register indexes (byte address is four times the index).
  localparam logic [INDEX_W-1:0] REG_REQUIRE_MASK   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_HB_TIMEOUT     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_MIN_HB_COUNT   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_HB_STABLE      = 3'd3;
  localparam logic [INDEX_W-1:0] REG_HEALTH_STABLE  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_MIN_CAM_FRAMES = 3'd5;

  // Register reset values.
  localparam logic [REQ_W-1:0]       RST_REQUIRE_MASK   = 3'd7;
  localparam logic [CFG_TIME_W-1:0]  RST_HB_TIMEOUT     = 32'd2000;
  localparam logic [CFG_COUNT_W-1:0] RST_MIN_HB_COUNT   = 16'd3;
  localparam logic [CFG_TIME_W-1:0]  RST_HB_STABLE      = 32'd3000;
  localparam logic [CFG_TIME_W-1:0]  RST_HEALTH_STABLE  = 32'd3000;
  localparam logic [CFG_COUNT_W-1:0] RST_MIN_CAM_FRAMES = 16'd10;

  // Bit positions in the require mask.
  localparam int REQ_PREARM = 0;
  localparam int REQ_RC     = 1;
  localparam int REQ_VISION = 2;

  // Bit positions in the latched flags.
  localparam int LF_HEALTH = 0;
  localparam int LF_PREARM = 1;
  localparam int LF_RC     = 2;
  localparam int LF_TELEM  = 3;
  localparam int LF_VISION = 4;

  // Bit positions in the unmet mask.
  localparam int UM_HEARTBEAT = 0;
  localparam int UM_HEALTH    = 1;
  localparam int UM_PREARM    = 2;
  localparam int UM_RC        = 3;
  localparam int UM_TELEM     = 4;
  localparam int UM_VISION    = 5;
  localparam int UM_FRAMES    = 6;

  // One request on the input channel.
  typedef struct packed {
    logic                func;
    logic [NOW_W-1:0]    now_tick;
    logic                hb_event;
    logic                heartbeat_valid;
    logic                heartbeat_fresh_in;
    logic [HEALTH_W-1:0] health_flags;
    logic                prearm_good;
    logic                rc_good;
    logic                telem_fresh;
    logic                vision_ready;
    logic                cam_frame;
  } item_t;

  // Configuration as seen by the evaluation logic.
  typedef struct packed {
    logic [REQ_W-1:0]       require_mask;
    logic [CFG_TIME_W-1:0]  heartbeat_timeout_ticks;
    logic [CFG_COUNT_W-1:0] min_heartbeat_count;
    logic [CFG_TIME_W-1:0]  heartbeat_stable_ticks;
    logic [CFG_TIME_W-1:0]  health_stable_ticks;
    logic [CFG_COUNT_W-1:0] min_camera_frames;
  } cfg_t;

  // One result request.
  typedef struct packed {
    logic                   ready_res;
    logic [UNMET_W-1:0]     unmet_mask;
    logic [OUT_COUNT_W-1:0] heartbeat_run;
    logic [OUT_COUNT_W-1:0] camera_frames_seen;
  } res_t;

endpackage

@@ hdl/preflight_readiness_qualifier.sv @@
// ----------------------------------------------------------------------------
// preflight_readiness_qualifier
// Qualifies vehicle readiness from status samples and time polls.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_ready) takes one request per cycle while not
// stalled: a status sample (in_func = 0) or a poll (in_func = 1), each with a
// tick timestamp. Every request yields exactly one result request on the output
// channel (out_valid / out_ready): a ready flag, the unmet-condition mask, the
// current heartbeat run length and the camera frame count.
// A request accepted into the input register is evaluated in a single pass and,
// once the result slot is free, stored into the result register, from which its
// result is offered.
// Throughput is one request per cycle while the receiver does not stall, with the
// tracking state updated in a single pass per request.
// When the receiver stalls, the result register holds its request and the
// input register keeps one more; in_ready drops only when both are full.
// Reset (rst_n low, synchronous) empties both registers, clears all tracking
// state and loads the register defaults. The user must write registers via the
// APB-style cfg_ port only while no request is in flight; this is not enforced.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module preflight_readiness_qualifier (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [prq_pkg::NOW_W-1:0]          in_now_tick,
  input  logic                               in_heartbeat_event,
  input  logic                               in_heartbeat_valid,
  input  logic                               in_heartbeat_fresh_in,
  input  logic [prq_pkg::HEALTH_W-1:0]       in_health_flags,
  input  logic                               in_prearm_healthy,
  input  logic                               in_rc_policy_ok,
  input  logic                               in_telemetry_fresh,
  input  logic                               in_vision_ready,
  input  logic                               in_camera_frame,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ready_res,
  output logic [prq_pkg::UNMET_W-1:0]        out_unmet_mask,
  output logic [prq_pkg::OUT_COUNT_W-1:0]    out_heartbeat_run,
  output logic [prq_pkg::OUT_COUNT_W-1:0]    out_camera_frames_seen,
  // Configuration port.
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [prq_pkg::ADDR_W-1:0]         cfg_paddr,
  input  logic [prq_pkg::DATA_W-1:0]         cfg_pwdata,
  output logic [prq_pkg::DATA_W-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  prq_pkg::cfg_t  cfg;
  prq_pkg::item_t in_item;
  prq_pkg::item_t item_r;
  prq_pkg::res_t  res;
  prq_pkg::res_t  res_r;
  logic           item_valid_r, item_valid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;
  logic           advance;
  logic           in_take;

  // Configuration registers.
  prq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Gather the input ports into one request.
  always_comb begin
    in_item.func               = in_func;
    in_item.now_tick           = in_now_tick;
    in_item.hb_event           = in_heartbeat_event;
    in_item.heartbeat_valid    = in_heartbeat_valid;
    in_item.heartbeat_fresh_in = in_heartbeat_fresh_in;
    in_item.health_flags       = in_health_flags;
    in_item.prearm_good        = in_prearm_healthy;
    in_item.rc_good            = in_rc_policy_ok;
    in_item.telem_fresh        = in_telemetry_fresh;
    in_item.vision_ready       = in_vision_ready;
    in_item.cam_frame          = in_camera_frame;
  end

  // Pipeline flow: the input register advances whenever the result slot frees.
  assign out_free       = !out_valid_r || out_ready;
  assign advance        = item_valid_r && out_free;
  assign in_ready       = !item_valid_r || advance;
  assign in_take        = in_valid && in_ready;
  assign item_valid_nxt = in_take || (item_valid_r && !advance);
  assign out_valid_nxt  = advance || (out_valid_r && !out_ready);

  // Evaluation of the registered request.
  prq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_item;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_ready_res          = res_r.ready_res;
  assign out_unmet_mask         = res_r.unmet_mask;
  assign out_heartbeat_run      = res_r.heartbeat_run;
  assign out_camera_frames_seen = res_r.camera_frames_seen;

  // Checks on the pipeline and the result encoding.
  `PRQ_ASSERT_IMPL(a_ready_matches_mask, out_valid_r, out_ready_res == (out_unmet_mask == '0), "ready flag disagrees with unmet mask")
  `PRQ_ASSERT_IMPL(a_full_blocks_input, item_valid_r && out_valid_r && !out_ready, !in_ready, "input taken while both stages are full")
  `PRQ_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r, "advanced request did not reach the result register")
  `PRQ_ASSERT_IMPL(a_short_run_unmet, out_valid_r && (prq_pkg::CNT_CMP_W'(out_heartbeat_run) < prq_pkg::CNT_CMP_W'(cfg.min_heartbeat_count)), out_unmet_mask[prq_pkg::UM_HEARTBEAT], "short heartbeat run reported as met")

endmodule

@@ hdl/prq_cfg.sv @@
// ----------------------------------------------------------------------------
// prq_cfg
// Configuration register file behind an APB-style slave port.
// ----------------------------------------------------------------------------
module prq_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prq_pkg::ADDR_W-1:0]   paddr,
  input  logic [prq_pkg::DATA_W-1:0]   pwdata,
  output logic [prq_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output prq_pkg::cfg_t                cfg
);

  logic [prq_pkg::INDEX_W-1:0] idx;
  logic                        wr_en;
  prq_pkg::cfg_t               cfg_r;
  prq_pkg::cfg_t               cfg_nxt;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign idx    = paddr[prq_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  // Write decode; addresses past the register list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        prq_pkg::REG_REQUIRE_MASK:
          cfg_nxt.require_mask = pwdata[prq_pkg::REQ_W-1:0];
        prq_pkg::REG_HB_TIMEOUT:
          cfg_nxt.heartbeat_timeout_ticks = pwdata[prq_pkg::CFG_TIME_W-1:0];
        prq_pkg::REG_MIN_HB_COUNT:
          cfg_nxt.min_heartbeat_count = pwdata[prq_pkg::CFG_COUNT_W-1:0];
        prq_pkg::REG_HB_STABLE:
          cfg_nxt.heartbeat_stable_ticks = pwdata[prq_pkg::CFG_TIME_W-1:0];
        prq_pkg::REG_HEALTH_STABLE:
          cfg_nxt.health_stable_ticks = pwdata[prq_pkg::CFG_TIME_W-1:0];
        prq_pkg::REG_MIN_CAM_FRAMES:
          cfg_nxt.min_camera_frames = pwdata[prq_pkg::CFG_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.require_mask            <= prq_pkg::RST_REQUIRE_MASK;
      cfg_r.heartbeat_timeout_ticks <= prq_pkg::RST_HB_TIMEOUT;
      cfg_r.min_heartbeat_count     <= prq_pkg::RST_MIN_HB_COUNT;
      cfg_r.heartbeat_stable_ticks  <= prq_pkg::RST_HB_STABLE;
      cfg_r.health_stable_ticks     <= prq_pkg::RST_HEALTH_STABLE;
      cfg_r.min_camera_frames       <= prq_pkg::RST_MIN_CAM_FRAMES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back, zero-extended to the bus width.
  always_comb begin
    case (idx)
      prq_pkg::REG_REQUIRE_MASK:
        prdata = prq_pkg::DATA_W'(cfg_r.require_mask);
      prq_pkg::REG_HB_TIMEOUT:
        prdata = prq_pkg::DATA_W'(cfg_r.heartbeat_timeout_ticks);
      prq_pkg::REG_MIN_HB_COUNT:
        prdata = prq_pkg::DATA_W'(cfg_r.min_heartbeat_count);
      prq_pkg::REG_HB_STABLE:
        prdata = prq_pkg::DATA_W'(cfg_r.heartbeat_stable_ticks);
      prq_pkg::REG_HEALTH_STABLE:
        prdata = prq_pkg::DATA_W'(cfg_r.health_stable_ticks);
      prq_pkg::REG_MIN_CAM_FRAMES:
        prdata = prq_pkg::DATA_W'(cfg_r.min_camera_frames);
      default:
        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/prq_core.sv @@
// ----------------------------------------------------------------------------
// prq_core
// Tracking state and single-pass readiness evaluation for one request.
// ----------------------------------------------------------------------------
module prq_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  prq_pkg::item_t item,
  input  prq_pkg::cfg_t  cfg,
  output prq_pkg::res_t  res
);

  localparam logic [prq_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

  logic [prq_pkg::TIME_BITS-1:0]  now;
  logic [prq_pkg::TIME_BITS-1:0]  since_last;
  logic [prq_pkg::TIME_BITS-1:0]  run_age;
  logic [prq_pkg::TIME_BITS-1:0]  health_age;
  logic                           timed_out;
  logic                           run_count_met;
  logic                           time_ok;
  logic                           health_held;
  logic [prq_pkg::UNMET_W-1:0]    unmet;

  logic [prq_pkg::COUNT_BITS-1:0] hb_run_count_r, hb_run_count_nxt;
  logic [prq_pkg::TIME_BITS-1:0]  hb_run_start_r, hb_run_start_nxt;
  logic                           hb_run_start_valid_r, hb_run_start_valid_nxt;
  logic [prq_pkg::TIME_BITS-1:0]  hb_last_time_r, hb_last_time_nxt;
  logic                           hb_last_time_valid_r, hb_last_time_valid_nxt;
  logic                           hb_last_ok_r, hb_last_ok_nxt;
  logic                           hb_fresh_r, hb_fresh_nxt;
  logic [prq_pkg::TIME_BITS-1:0]  health_start_r, health_start_nxt;
  logic                           health_start_valid_r, health_start_valid_nxt;
  logic [prq_pkg::FLAGS_W-1:0]    latched_flags_r, latched_flags_nxt;
  logic [prq_pkg::COUNT_BITS-1:0] frame_count_r, frame_count_nxt;

  assign now        = prq_pkg::TIME_BITS'(item.now_tick);
  assign since_last = now - hb_last_time_r;
  assign timed_out  = hb_last_time_valid_r &&
                      (prq_pkg::TIME_CMP_W'(since_last) >
                       prq_pkg::TIME_CMP_W'(cfg.heartbeat_timeout_ticks));

  // State update for a sample or a poll.
  always_comb begin
    hb_run_count_nxt       = hb_run_count_r;
    hb_run_start_nxt       = hb_run_start_r;
    hb_run_start_valid_nxt = hb_run_start_valid_r;
    hb_last_time_nxt       = hb_last_time_r;
    hb_last_time_valid_nxt = hb_last_time_valid_r;
    hb_last_ok_nxt         = hb_last_ok_r;
    hb_fresh_nxt           = hb_fresh_r;
    health_start_nxt       = health_start_r;
    health_start_valid_nxt = health_start_valid_r;
    latched_flags_nxt      = latched_flags_r;
    frame_count_nxt        = frame_count_r;
    if (item.func == prq_pkg::FUNC_POLL) begin
      // A poll drops the run while the last heartbeat is too old.
      if (timed_out) begin
        hb_run_count_nxt       = '0;
        hb_run_start_valid_nxt = 1'b0;
        hb_last_ok_nxt         = 1'b0;
        hb_fresh_nxt           = 1'b0;
      end
    end else begin
      // Heartbeat run bookkeeping.
      if (item.hb_event) begin
        if (item.heartbeat_valid) begin
          if (!hb_last_ok_r || !hb_run_start_valid_r) begin
            hb_run_start_nxt       = now;
            hb_run_start_valid_nxt = 1'b1;
            hb_run_count_nxt       = prq_pkg::COUNT_BITS'(1);
          end else if (hb_run_count_r != CNT_MAX) begin
            hb_run_count_nxt = hb_run_count_r + 1'b1;
          end
          hb_last_time_nxt       = now;
          hb_last_time_valid_nxt = 1'b1;
          hb_last_ok_nxt         = 1'b1;
          hb_fresh_nxt           = 1'b1;
        end else begin
          hb_run_count_nxt       = '0;
          hb_run_start_valid_nxt = 1'b0;
          hb_last_ok_nxt         = 1'b0;
          hb_fresh_nxt           = 1'b0;
        end
      end else begin
        hb_fresh_nxt = item.heartbeat_fresh_in;
      end
      // Latch the status inputs; prearm is waived when not required.
      latched_flags_nxt[prq_pkg::LF_HEALTH] = &item.health_flags;
      latched_flags_nxt[prq_pkg::LF_PREARM] = !cfg.require_mask[prq_pkg::REQ_PREARM] ||
                                              item.prearm_good;
      latched_flags_nxt[prq_pkg::LF_RC]     = item.rc_good;
      latched_flags_nxt[prq_pkg::LF_TELEM]  = item.telem_fresh;
      latched_flags_nxt[prq_pkg::LF_VISION] = item.vision_ready;
      if (item.cam_frame && (frame_count_r != CNT_MAX)) begin
        frame_count_nxt = frame_count_r + 1'b1;
      end
      // Health hold timer starts on the first healthy sample.
      if (&item.health_flags) begin
        if (!health_start_valid_r) begin
          health_start_nxt       = now;
          health_start_valid_nxt = 1'b1;
        end
      end else begin
        health_start_valid_nxt = 1'b0;
      end
    end
  end

  // Readiness judged on the updated state.
  assign run_age       = now - hb_run_start_nxt;
  assign health_age    = now - health_start_nxt;
  assign run_count_met = prq_pkg::CNT_CMP_W'(hb_run_count_nxt) >=
                         prq_pkg::CNT_CMP_W'(cfg.min_heartbeat_count);
  assign time_ok       = hb_run_start_valid_nxt &&
                         (prq_pkg::TIME_CMP_W'(run_age) >=
                          prq_pkg::TIME_CMP_W'(cfg.heartbeat_stable_ticks));
  assign health_held   = health_start_valid_nxt &&
                         (prq_pkg::TIME_CMP_W'(health_age) >=
                          prq_pkg::TIME_CMP_W'(cfg.health_stable_ticks));

  always_comb begin
    unmet = '0;
    unmet[prq_pkg::UM_HEARTBEAT] = !hb_fresh_nxt || !run_count_met || !time_ok;
    unmet[prq_pkg::UM_HEALTH]    = !latched_flags_nxt[prq_pkg::LF_HEALTH] ||
                                   !health_held;
    unmet[prq_pkg::UM_PREARM]    = !latched_flags_nxt[prq_pkg::LF_PREARM];
    unmet[prq_pkg::UM_RC]        = cfg.require_mask[prq_pkg::REQ_RC] &&
                                   !latched_flags_nxt[prq_pkg::LF_RC];
    unmet[prq_pkg::UM_TELEM]     = !latched_flags_nxt[prq_pkg::LF_TELEM];
    unmet[prq_pkg::UM_VISION]    = cfg.require_mask[prq_pkg::REQ_VISION] &&
                                   !latched_flags_nxt[prq_pkg::LF_VISION];
    unmet[prq_pkg::UM_FRAMES]    = cfg.require_mask[prq_pkg::REQ_VISION] &&
                                   (prq_pkg::CNT_CMP_W'(frame_count_nxt) <
                                    prq_pkg::CNT_CMP_W'(cfg.min_camera_frames));
  end

  assign res.ready_res          = (unmet == '0);
  assign res.unmet_mask         = unmet;
  assign res.heartbeat_run      = prq_pkg::OUT_COUNT_W'(hb_run_count_nxt);
  assign res.camera_frames_seen = prq_pkg::OUT_COUNT_W'(frame_count_nxt);

  // State commits only when the request moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_run_count_r       <= '0;
      hb_run_start_r       <= '0;
      hb_run_start_valid_r <= 1'b0;
      hb_last_time_r       <= '0;
      hb_last_time_valid_r <= 1'b0;
      hb_last_ok_r         <= 1'b0;
      hb_fresh_r           <= 1'b0;
      health_start_r       <= '0;
      health_start_valid_r <= 1'b0;
      latched_flags_r      <= '0;
      frame_count_r        <= '0;
    end else if (advance) begin
      hb_run_count_r       <= hb_run_count_nxt;
      hb_run_start_r       <= hb_run_start_nxt;
      hb_run_start_valid_r <= hb_run_start_valid_nxt;
      hb_last_time_r       <= hb_last_time_nxt;
      hb_last_time_valid_r <= hb_last_time_valid_nxt;
      hb_last_ok_r         <= hb_last_ok_nxt;
      hb_fresh_r           <= hb_fresh_nxt;
      health_start_r       <= health_start_nxt;
      health_start_valid_r <= health_start_valid_nxt;
      latched_flags_r      <= latched_flags_nxt;
      frame_count_r        <= frame_count_nxt;
    end
  end

endmodule
